### sv/mbea_pkg.sv
// ----------------------------------------------------------------------------
// mbea_pkg
// Shared types and constants of the monochrome bitmap edge antialias core.
// ----------------------------------------------------------------------------
package mbea_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 128;

    localparam int STORE_DEPTH = 2048;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 16;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

endpackage

### sv/mono_bitmap_edge_antialias_core.sv
// ----------------------------------------------------------------------------
// mono_bitmap_edge_antialias_core
// 1-bit column-major bitmap with byte writes and antialiased RGB565 queries.
// ----------------------------------------------------------------------------
// After reset the core sweeps its 2048 x 8 bitmap memory to zero, one byte a
// cycle, and takes no request until the sweep is done. A byte write is stored
// in the cycle it is taken. A query of a pixel off the screen gives black: it
// goes from S_IDLE to S_OUT and from there into the output register. Any other
// query reads the 5x5 window around the pixel through the single read port of
// the bitmap memory, one bit a cycle; a pixel that lies on an edge then also
// passes through the 8-step shift-subtract divider and the square of the
// S-curve. One request is in work at a time; the result sits in an output
// register, so the next request is taken while it waits.
module mono_bitmap_edge_antialias_core #(
    parameter int SCREEN_WIDTH  = mbea_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mbea_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: byte_address[10:0], byte_value[18:11], pixel_x[26:19],
    //        pixel_y[34:27], zero[39:35]
    input  logic [mbea_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // tuser: opcode[0]
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: pixel_color[15:0]
    output logic [mbea_pkg::OUT_DATA_W-1:0]     o_m_tdata
);
    import mbea_pkg::*;

    localparam int BYTES_PER_COL = (SCREEN_HEIGHT + 7) / 8;
    localparam logic [11:0]       W12   = 12'(SCREEN_WIDTH);
    localparam logic [11:0]       H12   = 12'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] BPC_A = ADDR_W'(BYTES_PER_COL);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_DIV, S_SQ, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic       valid;
        logic       inb;
        logic       centre;
        logic       near;
        logic [3:0] idx;
        logic [2:0] sh;
        logic [3:0] w;
    } t_rd;

    function automatic logic [3:0] ring_weight(input logic [1:0] ax, input logic [1:0] ay);
        logic [2:0] s;
        s = {1'b0, ax} + {1'b0, ay};
        if (s <= 3'd1)                 return 4'd8;
        else if (ax == 2'd1 && ay == 2'd1) return 4'd6;
        else if (s == 3'd2)            return 4'd4;
        else                           return 4'd2;
    endfunction

    // request fields
    logic [ADDR_W-1:0] in_addr;
    logic [7:0]        in_value, in_x, in_y;
    logic              in_acc;
    assign in_addr  = i_s_tdata[10:0];
    assign in_value = i_s_tdata[18:11];
    assign in_x     = i_s_tdata[26:19];
    assign in_y     = i_s_tdata[34:27];
    assign in_acc   = i_s_tvalid && o_s_tready;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [7:0]        r_x, r_y;
    logic signed [2:0] r_dx, r_dy;
    logic              r_issuing;
    t_rd               r_rd;
    logic [8:0]        r_nb, r_nin;
    logic [6:0]        r_sum, r_tot;
    logic [14:0]       r_rem, r_dsh;
    logic [2:0]        r_cnt;
    logic [7:0]        r_q;
    logic [13:0]       r_sq;
    logic [15:0]       r_res;
    logic              r_out_valid;
    logic [15:0]       r_out_data;

    // bitmap memory
    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        r_mem_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa, rd_addr;
    logic [7:0]        mem_wd;

    assign mem_we = (r_state == S_CLEAR) || (in_acc && i_s_tuser == OP_WRITE);
    assign mem_wa = (r_state == S_CLEAR) ? r_clr_addr : in_addr;
    assign mem_wd = (r_state == S_CLEAR) ? 8'd0 : in_value;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= mem[rd_addr];
    end

    // window address of the current tap
    logic [11:0]       nx, ny;
    logic [21:0]       col_prod;
    logic              tap_inb;
    logic [1:0]        ax, ay;
    logic [1:0]        dx1, dy1;
    t_rd               n_rd;

    always_comb begin
        nx       = {4'd0, r_x} + {{9{r_dx[2]}}, r_dx};
        ny       = {4'd0, r_y} + {{9{r_dy[2]}}, r_dy};
        col_prod = nx[10:0] * BPC_A;
        rd_addr  = col_prod[ADDR_W-1:0] + {3'd0, ny[10:3]};
        tap_inb  = !nx[11] && (nx < W12) && !ny[11] && (ny < H12);
        ax       = r_dx[2] ? 2'(-r_dx) : r_dx[1:0];
        ay       = r_dy[2] ? 2'(-r_dy) : r_dy[1:0];
        dx1      = 2'(r_dx + 3'sd1);
        dy1      = 2'(r_dy + 3'sd1);
        n_rd.valid  = r_issuing;
        n_rd.inb    = tap_inb;
        n_rd.centre = (r_dx == 3'sd0) && (r_dy == 3'sd0);
        n_rd.near   = (ax <= 2'd1) && (ay <= 2'd1);
        n_rd.idx    = {1'b0, dy1, 1'b0} + {2'd0, dy1} + {2'd0, dx1};
        n_rd.sh     = ~ny[2:0];
        n_rd.w      = ring_weight(ax, ay);
    end

    // edge test over the in-bounds 3x3 neighbors
    logic edge_hit;
    always_comb begin
        edge_hit = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4 && r_nin[i] && (r_nb[i] != r_nb[4])) edge_hit = 1'b1;
        end
    end

    logic        cap_bit;
    logic [6:0]  sum_f;
    logic [6:0]  sq_t;
    logic [6:0]  sq_v;
    logic [7:0]  g_c, g_s;
    assign cap_bit = r_mem_q[r_rd.sh] && r_rd.inb;
    assign sum_f   = r_sum + (r_nb[4] ? 7'd16 : 7'd0);
    assign sq_t    = r_q[7] ? ~r_q[6:0] : r_q[6:0];
    assign sq_v    = r_sq[13:7];

    always_comb begin
        g_c = r_q[7] ? (8'd255 - {1'b0, sq_v}) : {1'b0, sq_v};
        if (r_nb[4])          g_s = 8'd192 + {2'd0, g_c[7:2]};
        else if (g_c < 8'd64) g_s = {1'b0, g_c[7:1]};
        else                  g_s = g_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_issuing   <= 1'b0;
            r_rd.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd <= n_rd;
            if (r_out_valid && i_m_tready && r_state != S_OUT) r_out_valid <= 1'b0;

            // capture the bit read in the previous cycle
            if (r_rd.valid) begin
                if (r_rd.near) begin
                    r_nb[r_rd.idx]  <= cap_bit;
                    r_nin[r_rd.idx] <= r_rd.inb;
                end
                if (r_rd.inb && !r_rd.centre) begin
                    r_tot <= r_tot + {3'd0, r_rd.w};
                    if (cap_bit) r_sum <= r_sum + {3'd0, r_rd.w};
                end
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc && i_s_tuser == OP_QUERY) begin
                        r_x   <= in_x;
                        r_y   <= in_y;
                        r_dx  <= -3'sd2;
                        r_dy  <= -3'sd2;
                        r_sum <= '0;
                        r_tot <= 7'd16;
                        r_nin <= '0;
                        if (({4'd0, in_x} < W12) && ({4'd0, in_y} < H12)) begin
                            r_issuing <= 1'b1;
                            r_state   <= S_READ;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_READ: begin
                    if (r_issuing) begin
                        if (r_dx == 3'sd2) begin
                            r_dx <= -3'sd2;
                            r_dy <= r_dy + 3'sd1;
                            if (r_dy == 3'sd2) r_issuing <= 1'b0;
                        end else begin
                            r_dx <= r_dx + 3'sd1;
                        end
                    end else if (!r_rd.valid) begin
                        if (!edge_hit) begin
                            r_res   <= r_nb[4] ? 16'hFFFF : 16'h0000;
                            r_state <= S_OUT;
                        end else begin
                            // dividend = sum * 255, divisor aligned to quotient bit 7
                            r_rem   <= {sum_f, 8'd0} - {8'd0, sum_f};
                            r_dsh   <= {1'b0, r_tot, 7'd0};
                            r_cnt   <= 3'd7;
                            r_q     <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_rem >= r_dsh) begin
                        r_rem <= r_rem - r_dsh;
                        r_q   <= {r_q[6:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[6:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 3'd0) r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sq    <= sq_t * sq_t;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res   <= {g_s[7:3], g_s[7:2], g_s[7:3]};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### sv/mbea_checker.sv
// ----------------------------------------------------------------------------
// mbea_checker
// Port-level checks of the monochrome bitmap edge antialias core.
// ----------------------------------------------------------------------------
module mbea_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mbea_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import mbea_pkg::*;

    // the clearing pass follows reset, so no request is taken right after it
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("request taken during clearing pass");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("pending result dropped or changed");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_QUERY |=> !o_s_tready)
        else $error("query did not occupy the core");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_WRITE && !o_m_tvalid
        |=> !o_m_tvalid)
        else $error("byte write produced a result");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared with no query in work");

endmodule

bind mono_bitmap_edge_antialias_core mbea_checker u_mbea_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
